// ----- src/trrc_pkg.sv -----
// Shared types, register codes and wiring tables for the three-rotor reflector cipher
`timescale 1ns / 1ps
`default_nettype none

package trrc_pkg;

    // Last alphabet index, letter bounds and the codes of the configuration registers
    localparam logic [4:0] ALPHA_LAST = 5'd25;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;

    typedef enum logic [2:0] {
        CFG_LEFT_SEL     = 3'd0,
        CFG_MIDDLE_SEL   = 3'd1,
        CFG_RIGHT_SEL    = 3'd2,
        CFG_LEFT_START   = 3'd3,
        CFG_MIDDLE_START = 3'd4,
        CFG_RIGHT_START  = 3'd5
    } cfg_reg_t;

    // Wiring choice and head position of each slot, as seen by the datapath
    typedef struct packed {
        logic [2:0] sel_l;
        logic [2:0] sel_m;
        logic [2:0] sel_r;
        logic [4:0] head_l;
        logic [4:0] head_m;
        logic [4:0] head_r;
    } rotor_set_t;

    // Forward wirings, first letter in the top byte
    localparam logic [8*26-1:0] FWD_0 = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam logic [8*26-1:0] FWD_1 = "NOPQRSTUVWXYZABCDEFGHIJKLM";
    localparam logic [8*26-1:0] FWD_2 = "HIJKLMNOPQRSABCDEFGTUVWXYZ";
    localparam logic [8*26-1:0] FWD_3 = "JKLBCPQRSTUVDEFGHIZMNOWXYA";
    localparam logic [8*26-1:0] FWD_4 = "OPQRSTBCDENWIJKLMXYUVFGHAZ";

    // Inverse wirings: entry y holds the position that carries letter y
    localparam logic [8*26-1:0] INV_0 = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam logic [8*26-1:0] INV_1 = "NOPQRSTUVWXYZABCDEFGHIJKLM";
    localparam logic [8*26-1:0] INV_2 = "MNOPQRSABCDEFGHIJKLTUVWXYZ";
    localparam logic [8*26-1:0] INV_3 = "ZDEMNOPQRABCTUVFGHIJKLWXYS";
    localparam logic [8*26-1:0] INV_4 = "YGHIJVWXMNOPQKABCDEFTULRSZ";

    // Pick one letter of a wiring string as an index 0..25
    function automatic logic [4:0] letter_at(input logic [8*26-1:0] s, input logic [4:0] p);
        logic [4:0] slot;
        logic [7:0] ch;
        slot = ALPHA_LAST - p;
        ch   = s[8*slot +: 8];
        letter_at = 5'(ch - CHAR_A);
    endfunction

    // Forward wiring lookup
    function automatic logic [4:0] fwd_map(input logic [2:0] sel, input logic [4:0] p);
        unique case (sel)
            3'd0:    fwd_map = letter_at(FWD_0, p);
            3'd1:    fwd_map = letter_at(FWD_1, p);
            3'd2:    fwd_map = letter_at(FWD_2, p);
            3'd3:    fwd_map = letter_at(FWD_3, p);
            3'd4:    fwd_map = letter_at(FWD_4, p);
            default: fwd_map = p;
        endcase
    endfunction

    // Inverse wiring lookup
    function automatic logic [4:0] inv_map(input logic [2:0] sel, input logic [4:0] y);
        unique case (sel)
            3'd0:    inv_map = letter_at(INV_0, y);
            3'd1:    inv_map = letter_at(INV_1, y);
            3'd2:    inv_map = letter_at(INV_2, y);
            3'd3:    inv_map = letter_at(INV_3, y);
            3'd4:    inv_map = letter_at(INV_4, y);
            default: inv_map = y;
        endcase
    endfunction

    // Mod-26 add of two values below 26
    function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        add26 = (s > 6'(ALPHA_LAST)) ? 5'(s - 6'd26) : s[4:0];
    endfunction

    // Mod-26 subtract of two values below 26
    function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
        sub26 = (a < b) ? 5'(a + 5'd26 - b) : 5'(a - b);
    endfunction

    // Advance a head by one with wrap
    function automatic logic [4:0] inc26(input logic [4:0] a);
        inc26 = (a == ALPHA_LAST) ? 5'd0 : 5'(a + 5'd1);
    endfunction

    // Fold selector codes five to seven onto the five wirings
    function automatic logic [2:0] wrap_sel(input logic [2:0] sel);
        wrap_sel = (sel > 3'd4) ? 3'(sel - 3'd5) : sel;
    endfunction

    // Fold start offsets 26 to 31 back into range
    function automatic logic [4:0] wrap_offset(input logic [4:0] off);
        wrap_offset = (off > ALPHA_LAST) ? 5'(off - 5'd26) : off;
    endfunction

endpackage

`default_nettype wire

// ----- src/three_rotor_reflector_cipher.sv -----
// Dataflow: an accepted item is loaded into the input register and moves on to the
// result register once the result register is free.
// Throughput: one item per cycle while results are taken; the rotor heads
// are read and stepped in the same stage, so consecutive letters see the
// correct odometer position. Reset (rst_n low, asynchronous): heads at zero,
// selectors 0/1/2, offsets 0, both stages empty.
// Top level of the three-rotor reflector cipher
`timescale 1ns / 1ps
`default_nettype none

module three_rotor_reflector_cipher
    import trrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Input items
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  wire logic [0:0] s_axis_tuser,   // [0] req_type
    // Result items
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata,   // [7:0] char_out
    // Configuration writes
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [4:0] cfg_data
);

    logic       in_valid_reg;
    logic       in_req_reg;
    logic [7:0] in_char_reg;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;

    logic [2:0] sel_l_reg;
    logic [2:0] sel_m_reg;
    logic [2:0] sel_r_reg;
    logic [4:0] start_l_reg;
    logic [4:0] start_m_reg;
    logic [4:0] start_r_reg;
    logic [4:0] head_l_reg;
    logic [4:0] head_m_reg;
    logic [4:0] head_r_reg;
    logic [4:0] head_l_next;
    logic [4:0] head_m_next;
    logic [4:0] head_r_next;

    logic       out_free;
    logic       advance;
    logic       is_letter;
    logic [7:0] cipher_char;
    rotor_set_t rotors;

    // Handshake between the two stages
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_l_reg   <= 3'd0;
            sel_m_reg   <= 3'd1;
            sel_r_reg   <= 3'd2;
            start_l_reg <= 5'd0;
            start_m_reg <= 5'd0;
            start_r_reg <= 5'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LEFT_SEL:     sel_l_reg   <= wrap_sel(cfg_data[2:0]);
                CFG_MIDDLE_SEL:   sel_m_reg   <= wrap_sel(cfg_data[2:0]);
                CFG_RIGHT_SEL:    sel_r_reg   <= wrap_sel(cfg_data[2:0]);
                CFG_LEFT_START:   start_l_reg <= wrap_offset(cfg_data);
                CFG_MIDDLE_START: start_m_reg <= wrap_offset(cfg_data);
                CFG_RIGHT_START:  start_r_reg <= wrap_offset(cfg_data);
                default:          ;
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_req_reg  <= s_axis_tuser[0];
            in_char_reg <= s_axis_tdata;
        end
    end

    // Encipher the held item
    assign rotors = '{sel_l:  sel_l_reg,  sel_m:  sel_m_reg,  sel_r:  sel_r_reg,
                      head_l: head_l_reg, head_m: head_m_reg, head_r: head_r_reg};

    trrc_datapath u_datapath (
        .char_in   (in_char_reg),
        .rotors    (rotors),
        .is_letter (is_letter),
        .char_out  (cipher_char)
    );

    // Reload or step the heads as the item moves on
    always_comb
    begin
        head_l_next = head_l_reg;
        head_m_next = head_m_reg;
        head_r_next = head_r_reg;
        priority if (advance && in_req_reg)
        begin
            head_l_next = start_l_reg;
            head_m_next = start_m_reg;
            head_r_next = start_r_reg;
        end
        else if (advance && is_letter)
        begin
            head_r_next = inc26(head_r_reg);
            if (head_r_reg == ALPHA_LAST)
            begin
                head_m_next = inc26(head_m_reg);
                if (head_m_reg == ALPHA_LAST)
                begin
                    head_l_next = inc26(head_l_reg);
                end
            end
        end
        else
        begin
            head_r_next = head_r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_l_reg <= 5'd0;
            head_m_reg <= 5'd0;
            head_r_reg <= 5'd0;
        end
        else
        begin
            head_l_reg <= head_l_next;
            head_m_reg <= head_m_next;
            head_r_reg <= head_r_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload: a reload echoes its byte
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_char_reg <= in_req_reg ? in_char_reg : cipher_char;
        end
    end

`ifndef SYNTHESIS
    a_heads_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_l_reg <= ALPHA_LAST) && (head_m_reg <= ALPHA_LAST) && (head_r_reg <= ALPHA_LAST))
        else $error("rotor head outside the alphabet");

    a_heads_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(head_l_reg) && $stable(head_m_reg) && $stable(head_r_reg))
        else $error("rotor heads moved without an item");

    a_reload_heads: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_req_reg |=> (head_l_reg == $past(start_l_reg))
            && (head_m_reg == $past(start_m_reg)) && (head_r_reg == $past(start_r_reg)))
        else $error("reload did not load the start offsets");

    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !is_letter |=> out_char_reg == $past(in_char_reg))
        else $error("non-letter byte altered");

    a_letter_stays_letter: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_req_reg && is_letter |=>
            (out_char_reg >= CHAR_A) && (out_char_reg <= CHAR_Z)
            && (out_char_reg != $past(in_char_reg)))
        else $error("letter enciphered to itself or to a non-letter");
`endif

endmodule

`default_nettype wire

// ----- src/trrc_datapath.sv -----
// Combinational rotor, reflector and return path for one character
`timescale 1ns / 1ps
`default_nettype none

module trrc_datapath
    import trrc_pkg::*;
(
    input  wire logic       [7:0] char_in,
    input  wire rotor_set_t       rotors,
    output logic                  is_letter,
    output logic            [7:0] char_out
);

    logic [4:0] v_in;
    logic [4:0] v_r;
    logic [4:0] v_m;
    logic [4:0] v_l;
    logic [4:0] v_refl;
    logic [4:0] v_il;
    logic [4:0] v_im;
    logic [4:0] v_ir;

    // Classify the byte
    assign is_letter = (char_in >= CHAR_A) && (char_in <= CHAR_Z);
    assign v_in      = 5'(char_in - CHAR_A);

    // Pass right to left through the rotors
    assign v_r = fwd_map(rotors.sel_r, add26(rotors.head_r, v_in));
    assign v_m = fwd_map(rotors.sel_m, add26(rotors.head_m, v_r));
    assign v_l = fwd_map(rotors.sel_l, add26(rotors.head_l, v_m));

    // Reflect
    assign v_refl = ALPHA_LAST - v_l;

    // Return left to right through the inverse wirings
    assign v_il = sub26(inv_map(rotors.sel_l, v_refl), rotors.head_l);
    assign v_im = sub26(inv_map(rotors.sel_m, v_il), rotors.head_m);
    assign v_ir = sub26(inv_map(rotors.sel_r, v_im), rotors.head_r);

    // Letters leave enciphered, anything else unchanged
    assign char_out = is_letter ? (CHAR_A + {3'b000, v_ir}) : char_in;

endmodule

`default_nettype wire
